FILE: hdl/sm4_block_cipher_ecb_cbc_core_macros.svh
// Assertion macros shared by the SM4 engine RTL.
`ifndef SM4_BLOCK_CIPHER_ECB_CBC_CORE_MACROS_SVH
`define SM4_BLOCK_CIPHER_ECB_CBC_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds at every rising edge out of reset.
`define SM4_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never occurs out of reset.
`define SM4_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define SM4_ASSERT(lbl, clk, rst, prop, msg)
`define SM4_ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

FILE: hdl/sm4_pkg.sv
// Types, constants and functions shared by the SM4 engine modules.
package sm4_pkg;

   localparam int unsigned ROUND_COUNT = 32;
   localparam int unsigned CNT_W       = $clog2(ROUND_COUNT);
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned HALF_W      = 64;
   localparam int unsigned CSR_IDX_W   = 3;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_HI  = 3'd0,
      CSR_KEY_LO  = 3'd1,
      CSR_IV_HI   = 3'd2,
      CSR_IV_LO   = 3'd3,
      CSR_CHAIN   = 3'd4,
      CSR_DECRYPT = 3'd5
   } csr_index_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEYEXP,
      ST_PRIME,
      ST_ROUNDS,
      ST_DRAIN
   } sm4_state_type;

   // Round key store write port
   typedef struct packed {
      logic              en;
      logic [CNT_W-1:0]  addr;
      logic [WORD_W-1:0] data;
   } rk_wr_type;

   localparam logic [WORD_W-1:0] FK0 = 32'ha3b1bac6;
   localparam logic [WORD_W-1:0] FK1 = 32'h56aa3350;
   localparam logic [WORD_W-1:0] FK2 = 32'h677d9197;
   localparam logic [WORD_W-1:0] FK3 = 32'hb27022dc;

   localparam logic [7:0] SBOX_TAB [256] = '{
      8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,
      8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
      8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,
      8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,
      8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
      8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,
      8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
      8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,
      8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
      8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,
      8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
      8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,
      8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
      8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,
      8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
      8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,
      8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
      8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,
      8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
      8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,
      8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
      8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,
      8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
      8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,
      8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
      8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,
      8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
      8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,
      8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
      8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,
      8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
   };

   // Byte-wise S-box substitution
   function automatic logic [WORD_W-1:0] tau(input logic [WORD_W-1:0] a);
      tau = {SBOX_TAB[a[31:24]], SBOX_TAB[a[23:16]], SBOX_TAB[a[15:8]], SBOX_TAB[a[7:0]]};
   endfunction

   // Linear map of the data rounds
   function automatic logic [WORD_W-1:0] lin_data(input logic [WORD_W-1:0] b);
      lin_data = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                   ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
   endfunction

   // Linear map of the key schedule
   function automatic logic [WORD_W-1:0] lin_key(input logic [WORD_W-1:0] b);
      lin_key = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
   endfunction

   // CK constant of step i: byte j is 7 * (4i + j) mod 256
   function automatic logic [WORD_W-1:0] ck_word(input logic [CNT_W-1:0] i);
      logic [WORD_W-1:0] w;
      logic [6:0]        idx;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         idx = {i, 2'(j)};
         w   = {w[23:0], 8'({1'b0, idx} * 8'd7)};
      end
      return w;
   endfunction

endpackage

FILE: hdl/sm4_round.sv
// Shared SM4 round unit: one data round or one key schedule step.
module sm4_round
   import sm4_pkg::*;
(
   input  logic [WORD_W-1:0] w0,
   input  logic [WORD_W-1:0] w1,
   input  logic [WORD_W-1:0] w2,
   input  logic [WORD_W-1:0] w3,
   input  logic [WORD_W-1:0] rk,
   input  logic              key_sched,
   output logic [WORD_W-1:0] w_new
);

   logic [WORD_W-1:0] sub;

   // Mix the three newest words with the round key or CK constant, substitute, diffuse
   always_comb begin
      sub   = tau(w1 ^ w2 ^ w3 ^ rk);
      w_new = w0 ^ (key_sched ? lin_key(sub) : lin_data(sub));
   end

endmodule

FILE: hdl/sm4_rkmem.sv
// Round key store: 32 words, one write port and one registered read port.
module sm4_rkmem
   import sm4_pkg::*;
(
   input  logic              clock,
   input  rk_wr_type         wr,
   input  logic [CNT_W-1:0]  rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [ROUND_COUNT];
   logic [WORD_W-1:0] rd_data_ff;

   // Write a key during expansion
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Register the read word
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/sm4_block_cipher_ecb_cbc_core.sv
// SM4 block cipher engine, ECB or CBC, one 128-bit block per request beat.
// Configuration: csr_wr_en writes csr_wr_data into register csr_index
// (key hi/lo, IV hi/lo, chain mode, direction); write only while idle.
// A key or direction write marks the round keys stale; the next block first
// runs 32 key schedule steps through the shared round unit, then a prime
// state that starts the key store read.
// Request: req_valid with block and new_message; accepted when req_stall is
// low, which holds only while the sequencer idles. The next block is taken
// while an earlier result still waits at the output register.
// Blocks are handled one at a time: a new block is taken only after the
// previous one has run its 32 rounds and its output cycle, bound by the
// single shared round unit.
// Result: rsp_valid stays high with rsp_out_hi/lo held until a cycle with
// rsp_stall low; a stalled result holds the sequencer in its output cycle.
// Reset: synchronous; clears control, config and chaining regs, marks keys stale.
`include "sm4_block_cipher_ecb_cbc_core_macros.svh"

module sm4_block_cipher_ecb_cbc_core
   import sm4_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [HALF_W-1:0]    csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [HALF_W-1:0]    req_block_hi,
   input  logic [HALF_W-1:0]    req_block_lo,
   input  logic                 req_new_message,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [HALF_W-1:0]    rsp_out_hi,
   output logic [HALF_W-1:0]    rsp_out_lo
);

   // Configuration registers
   logic [HALF_W-1:0] key_hi_ff, key_lo_ff, iv_hi_ff, iv_lo_ff;
   logic              chain_mode_ff, decrypt_dir_ff, keys_stale_ff;

   // Sequencer and working state
   sm4_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] kw_ff [4];
   logic [WORD_W-1:0] x_ff [4];
   logic [HALF_W-1:0] mask_hi_ff, mask_lo_ff;
   logic [HALF_W-1:0] chain_hi_ff, chain_lo_ff;
   logic              rsp_valid_ff;
   logic [HALF_W-1:0] rsp_hi_ff, rsp_lo_ff;

   // Control
   logic              req_accept, cnt_last, slot_free;
   logic              key_step, round_step, drain_go;
   logic              cbc, cbc_enc, cbc_dec;
   logic [HALF_W-1:0] chain_eff_hi, chain_eff_lo;
   logic [HALF_W-1:0] res_hi, res_lo;
   logic [CNT_W-1:0]  rd_addr;
   logic [WORD_W-1:0] rk_word;
   logic [WORD_W-1:0] u_w0, u_w1, u_w2, u_w3, u_rk, u_new;
   rk_wr_type         rk_wr;

   assign req_accept = req_valid && !req_stall;
   assign cnt_last   = (cnt_ff == CNT_W'(ROUND_COUNT - 1));
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign cbc        = chain_mode_ff;
   assign cbc_enc    = chain_mode_ff && !decrypt_dir_ff;
   assign cbc_dec    = chain_mode_ff && decrypt_dir_ff;

   // Chaining value for this block, from the IV on a new message
   assign chain_eff_hi = (cbc && req_new_message) ? iv_hi_ff : chain_hi_ff;
   assign chain_eff_lo = (cbc && req_new_message) ? iv_lo_ff : chain_lo_ff;

   // Final words come out in reverse order, then the decrypt mask
   assign res_hi = {x_ff[3], x_ff[2]} ^ mask_hi_ff;
   assign res_lo = {x_ff[1], x_ff[0]} ^ mask_lo_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = keys_stale_ff ? ST_KEYEXP : ST_ROUNDS;
            end
         end
         ST_KEYEXP: begin
            if (cnt_last) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            state_in = ST_ROUNDS;
         end
         ST_ROUNDS: begin
            if (cnt_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      req_stall  = 1'b1;
      key_step   = 1'b0;
      round_step = 1'b0;
      drain_go   = 1'b0;
      rd_addr    = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_KEYEXP: begin
            key_step = 1'b1;
         end
         ST_PRIME: begin
            rd_addr = '0;
         end
         ST_ROUNDS: begin
            round_step = 1'b1;
            rd_addr    = cnt_ff + 1'b1;
         end
         ST_DRAIN: begin
            drain_go = slot_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Advance the step counter while the round unit runs, wrap to zero after
   assign cnt_in = (key_step || round_step) ? cnt_ff + 1'b1 : '0;

   // Feed the shared round unit from the key or the data words
   always_comb begin
      if (key_step) begin
         u_w0 = kw_ff[0];
         u_w1 = kw_ff[1];
         u_w2 = kw_ff[2];
         u_w3 = kw_ff[3];
         u_rk = ck_word(cnt_ff);
      end else begin
         u_w0 = x_ff[0];
         u_w1 = x_ff[1];
         u_w2 = x_ff[2];
         u_w3 = x_ff[3];
         u_rk = rk_word;
      end
   end

   sm4_round u_round (
      .w0        (u_w0),
      .w1        (u_w1),
      .w2        (u_w2),
      .w3        (u_w3),
      .rk        (u_rk),
      .key_sched (key_step),
      .w_new     (u_new)
   );

   // Store each new key, mirrored for decryption
   always_comb begin
      rk_wr.en   = key_step;
      rk_wr.addr = decrypt_dir_ff ? ~cnt_ff : cnt_ff;
      rk_wr.data = u_new;
   end

   sm4_rkmem u_rkmem (
      .clock   (clock),
      .wr      (rk_wr),
      .rd_addr (rd_addr),
      .rd_data (rk_word)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         keys_stale_ff <= 1'b1;
         chain_mode_ff <= 1'b0;
         decrypt_dir_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         // hold the result until taken, then drop or refill
         if (drain_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         // keys become fresh at the end of expansion, stale on key or direction writes
         if (csr_wr_en && (csr_index == CSR_KEY_HI || csr_index == CSR_KEY_LO
                           || csr_index == CSR_DECRYPT)) begin
            keys_stale_ff <= 1'b1;
         end else if (key_step && cnt_last) begin
            keys_stale_ff <= 1'b0;
         end
         if (csr_wr_en && csr_index == CSR_CHAIN) begin
            chain_mode_ff <= csr_wr_data[0];
         end
         if (csr_wr_en && csr_index == CSR_DECRYPT) begin
            decrypt_dir_ff <= csr_wr_data[0];
         end
      end
   end

   // Wide configuration registers and chaining value
   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff   <= '0;
         key_lo_ff   <= '0;
         iv_hi_ff    <= '0;
         iv_lo_ff    <= '0;
         chain_hi_ff <= '0;
         chain_lo_ff <= '0;
      end else begin
         if (csr_wr_en && csr_index == CSR_KEY_HI) begin
            key_hi_ff <= csr_wr_data;
         end
         if (csr_wr_en && csr_index == CSR_KEY_LO) begin
            key_lo_ff <= csr_wr_data;
         end
         if (csr_wr_en && csr_index == CSR_IV_HI) begin
            iv_hi_ff <= csr_wr_data;
         end
         if (csr_wr_en && csr_index == CSR_IV_LO) begin
            iv_lo_ff <= csr_wr_data;
         end
         // decrypt chains on the ciphertext in, encrypt on the result out
         if (req_accept && cbc_dec) begin
            chain_hi_ff <= req_block_hi;
            chain_lo_ff <= req_block_lo;
         end else if (drain_go && cbc_enc) begin
            chain_hi_ff <= res_hi;
            chain_lo_ff <= res_lo;
         end
      end
   end

   // Working words, decrypt mask and result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kw_ff[0] <= key_hi_ff[63:32] ^ FK0;
         kw_ff[1] <= key_hi_ff[31:0]  ^ FK1;
         kw_ff[2] <= key_lo_ff[63:32] ^ FK2;
         kw_ff[3] <= key_lo_ff[31:0]  ^ FK3;
         if (cbc_enc) begin
            {x_ff[0], x_ff[1]} <= req_block_hi ^ chain_eff_hi;
            {x_ff[2], x_ff[3]} <= req_block_lo ^ chain_eff_lo;
         end else begin
            {x_ff[0], x_ff[1]} <= req_block_hi;
            {x_ff[2], x_ff[3]} <= req_block_lo;
         end
         mask_hi_ff <= cbc_dec ? chain_eff_hi : '0;
         mask_lo_ff <= cbc_dec ? chain_eff_lo : '0;
      end else if (key_step) begin
         kw_ff[0] <= kw_ff[1];
         kw_ff[1] <= kw_ff[2];
         kw_ff[2] <= kw_ff[3];
         kw_ff[3] <= u_new;
      end else if (round_step) begin
         x_ff[0] <= x_ff[1];
         x_ff[1] <= x_ff[2];
         x_ff[2] <= x_ff[3];
         x_ff[3] <= u_new;
      end
      if (drain_go) begin
         rsp_hi_ff <= res_hi;
         rsp_lo_ff <= res_lo;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_hi = rsp_hi_ff;
   assign rsp_out_lo = rsp_lo_ff;

   // Assertions
   `SM4_ASSERT(a_keyexp_only_stale, clock, reset, (state_ff == ST_KEYEXP) |-> keys_stale_ff, "key expansion running with fresh keys")
   `SM4_ASSERT(a_rounds_start_zero, clock, reset, (state_ff == ST_ROUNDS && $past(state_ff) != ST_ROUNDS) |-> (cnt_ff == '0), "rounds started with nonzero count")
   `SM4_ASSERT_NEVER(a_drain_count, clock, reset, (state_ff == ST_DRAIN && cnt_ff != '0), "output cycle reached before all rounds")
   `SM4_ASSERT(a_rsp_from_drain, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DRAIN), "result raised outside the output cycle")

endmodule
